// ===== hw/rtl/dbt_pkg.sv =====
`timescale 1ns / 1ps
// Package for the DRAM bank timing state machine.
// Holds command and bank state codes, register indexes and default settings.
// No dependencies.
package dbt_pkg;

   // Command codes carried in req_func
   typedef enum logic [2:0] {
      FUNC_ACTIVATE  = 3'd0,
      FUNC_READ      = 3'd1,
      FUNC_WRITE     = 3'd2,
      FUNC_PRECHARGE = 3'd3,
      FUNC_REFRESH   = 3'd4,
      FUNC_TICK      = 3'd5
   } func_type;

   // Bank states reported in rsp_bank_state
   typedef enum logic [2:0] {
      ST_IDLE        = 3'd0,
      ST_ACTIVATING  = 3'd1,
      ST_ACTIVE      = 3'd2,
      ST_READING     = 3'd3,
      ST_WRITING     = 3'd4,
      ST_PRECHARGING = 3'd5,
      ST_REFRESHING  = 3'd6
   } bank_state_type;

   // Timing register indexes on the csr port
   typedef enum logic [2:0] {
      CSR_T_RCD = 3'd0,
      CSR_T_RP  = 3'd1,
      CSR_T_RAS = 3'd2,
      CSR_T_RC  = 3'd3,
      CSR_T_CAS = 3'd4,
      CSR_T_CCD = 3'd5,
      CSR_T_WR  = 3'd6,
      CSR_T_RFC = 3'd7
   } csr_index_type;

   localparam int TMG_W  = 10;
   localparam int RFC_W  = 12;
   localparam int GAP_W  = 12;

   // Timing register reset values
   localparam logic [TMG_W-1:0] RST_T_RCD = 10'd22;
   localparam logic [TMG_W-1:0] RST_T_RP  = 10'd22;
   localparam logic [TMG_W-1:0] RST_T_RAS = 10'd52;
   localparam logic [TMG_W-1:0] RST_T_RC  = 10'd74;
   localparam logic [TMG_W-1:0] RST_T_CAS = 10'd22;
   localparam logic [TMG_W-1:0] RST_T_CCD = 10'd8;
   localparam logic [TMG_W-1:0] RST_T_WR  = 10'd24;
   localparam logic [RFC_W-1:0] RST_T_RFC = 12'd560;

   // Default module parameters
   localparam int DEF_ACT_WINDOW = 4;
   localparam int DEF_T_FAW      = 48;
   localparam int DEF_T_WTR      = 12;
   localparam int DEF_ROW_BITS   = 17;
   localparam int DEF_CYCLE_BITS = 32;

endpackage

// ===== hw/rtl/dram_bank_timing_fsm.sv =====
`timescale 1ns / 1ps
// Top level of the DRAM bank timing state machine: input stage, legality
// checks, bank state update and result register. Uses dbt_pkg.

// One command transaction enters per clock while rsp_ready keeps up; it passes
// the input register, then the result register. Sustained rate is one command
// per cycle with rsp_ready high: the bank state, the last-command cycle stamps
// and the activate window are all updated as a command moves from the input
// to the result register, through one set of parallel 33-bit compares. The
// input stage keeps taking commands while a result waits on rsp_ready, until
// both registers are full. Timing registers are written through the csr port,
// which is always ready; write them only while the block is idle.
module dram_bank_timing_fsm #(
   parameter int ACT_WINDOW = dbt_pkg::DEF_ACT_WINDOW,
   parameter int T_FAW      = dbt_pkg::DEF_T_FAW,
   parameter int T_WTR      = dbt_pkg::DEF_T_WTR,
   parameter int ROW_BITS   = dbt_pkg::DEF_ROW_BITS,
   parameter int CYCLE_BITS = dbt_pkg::DEF_CYCLE_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   // command channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [2:0]            req_func,
   input  logic [CYCLE_BITS-1:0] req_cycle,
   input  logic [ROW_BITS-1:0]   req_row,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_accepted,
   output logic [2:0]            rsp_bank_state,
   output logic [ROW_BITS-1:0]   rsp_open_row,
   // timing register write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [2:0]            csr_index,
   input  logic [11:0]           csr_data
);

   localparam int SUM_W = CYCLE_BITS + 1;
   localparam int CNT_W = $clog2(ACT_WINDOW + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ACT_WINDOW);
   localparam logic [dbt_pkg::GAP_W-1:0] FAW_GAP = dbt_pkg::GAP_W'(T_FAW);
   localparam logic [dbt_pkg::GAP_W-1:0] WTR_GAP = dbt_pkg::GAP_W'(T_WTR);

   // True when a recorded stamp plus gap still lies beyond the given cycle
   function automatic logic too_soon(input logic vld, input logic [CYCLE_BITS-1:0] at,
                                     input logic [CYCLE_BITS-1:0] cyc,
                                     input logic [dbt_pkg::GAP_W-1:0] gap);
      logic [SUM_W-1:0] lim;
      lim = {1'b0, at} + SUM_W'(gap);
      return vld && ({1'b0, cyc} < lim);
   endfunction

   // Timing registers
   logic [dbt_pkg::TMG_W-1:0] t_rcd_ff, t_rp_ff, t_ras_ff, t_rc_ff;
   logic [dbt_pkg::TMG_W-1:0] t_cas_ff, t_ccd_ff, t_wr_ff;
   logic [dbt_pkg::RFC_W-1:0] t_rfc_ff;

   // Input stage
   logic                  in_vld_ff, in_vld_in;
   logic [2:0]            in_func_ff;
   logic [CYCLE_BITS-1:0] in_cycle_ff;
   logic [ROW_BITS-1:0]   in_row_ff;

   // Bank state
   dbt_pkg::bank_state_type state_ff, state_in;
   logic [ROW_BITS-1:0]   row_ff, row_in;
   logic [SUM_W-1:0]      busy_until_ff, busy_until_in;
   logic                  busy_vld_ff, busy_vld_in;
   logic [CYCLE_BITS-1:0] last_act_ff, last_act_in, last_pre_ff, last_pre_in;
   logic [CYCLE_BITS-1:0] last_rd_ff, last_rd_in, last_wr_ff, last_wr_in;
   logic                  act_vld_ff, act_vld_in, pre_vld_ff, pre_vld_in;
   logic                  rd_vld_ff, rd_vld_in, wr_vld_ff, wr_vld_in;
   logic [CYCLE_BITS-1:0] win_ff [ACT_WINDOW];
   logic [CYCLE_BITS-1:0] win_in [ACT_WINDOW];
   logic [CNT_W-1:0]      cnt_ff, cnt_in;

   // Result register
   logic                  rsp_vld_ff, rsp_vld_in;
   logic                  rsp_acc_ff;
   dbt_pkg::bank_state_type rsp_state_ff;
   logic [ROW_BITS-1:0]   rsp_row_ff;

   logic advance;
   logic ok;
   logic col_ok;
   logic tick_due;
   logic [SUM_W-1:0] cyc_ext;

   // Move the staged command through when the result register is free
   assign advance   = in_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;
   assign csr_ready = 1'b1;

   assign cyc_ext  = {1'b0, in_cycle_ff};
   assign col_ok   = (state_ff == dbt_pkg::ST_ACTIVE) || (state_ff == dbt_pkg::ST_READING) ||
                     (state_ff == dbt_pkg::ST_WRITING);
   assign tick_due = busy_vld_ff && (cyc_ext >= busy_until_ff);

   // Decide whether the staged command is legal
   always_comb begin
      ok = 1'b0;
      unique case (dbt_pkg::func_type'(in_func_ff))
         dbt_pkg::FUNC_ACTIVATE: begin
            ok = (state_ff == dbt_pkg::ST_IDLE) &&
                 !too_soon(cnt_ff == CNT_FULL, win_ff[0], in_cycle_ff, FAW_GAP) &&
                 !too_soon(pre_vld_ff, last_pre_ff, in_cycle_ff, dbt_pkg::GAP_W'(t_rp_ff)) &&
                 !too_soon(act_vld_ff, last_act_ff, in_cycle_ff, dbt_pkg::GAP_W'(t_rc_ff));
         end
         dbt_pkg::FUNC_READ: begin
            ok = col_ok &&
                 !too_soon(rd_vld_ff, last_rd_ff, in_cycle_ff, dbt_pkg::GAP_W'(t_ccd_ff)) &&
                 !too_soon(wr_vld_ff, last_wr_ff, in_cycle_ff, WTR_GAP);
         end
         dbt_pkg::FUNC_WRITE: begin
            ok = col_ok &&
                 !too_soon(wr_vld_ff, last_wr_ff, in_cycle_ff, dbt_pkg::GAP_W'(t_ccd_ff)) &&
                 !too_soon(rd_vld_ff, last_rd_ff, in_cycle_ff, dbt_pkg::GAP_W'(t_cas_ff));
         end
         dbt_pkg::FUNC_PRECHARGE: begin
            ok = (state_ff == dbt_pkg::ST_ACTIVE) &&
                 !too_soon(act_vld_ff, last_act_ff, in_cycle_ff, dbt_pkg::GAP_W'(t_ras_ff)) &&
                 !too_soon(wr_vld_ff, last_wr_ff, in_cycle_ff, dbt_pkg::GAP_W'(t_wr_ff));
         end
         dbt_pkg::FUNC_REFRESH: ok = (state_ff == dbt_pkg::ST_IDLE);
         dbt_pkg::FUNC_TICK:    ok = 1'b1;
         default:               ok = 1'b0;
      endcase
   end

   // Next bank state, stamps and activate window
   always_comb begin
      state_in      = state_ff;
      row_in        = row_ff;
      busy_until_in = busy_until_ff;
      busy_vld_in   = busy_vld_ff;
      last_act_in   = last_act_ff;
      last_pre_in   = last_pre_ff;
      last_rd_in    = last_rd_ff;
      last_wr_in    = last_wr_ff;
      act_vld_in    = act_vld_ff;
      pre_vld_in    = pre_vld_ff;
      rd_vld_in     = rd_vld_ff;
      wr_vld_in     = wr_vld_ff;
      win_in        = win_ff;
      cnt_in        = cnt_ff;
      if (advance && ok) begin
         unique case (dbt_pkg::func_type'(in_func_ff))
            dbt_pkg::FUNC_ACTIVATE: begin
               state_in      = dbt_pkg::ST_ACTIVATING;
               row_in        = in_row_ff;
               busy_until_in = cyc_ext + SUM_W'(t_rcd_ff);
               busy_vld_in   = 1'b1;
               last_act_in   = in_cycle_ff;
               act_vld_in    = 1'b1;
               // shift the window; the oldest entry sits at index 0 once full
               for (int i = 0; i < ACT_WINDOW - 1; i++) begin
                  win_in[i] = win_ff[i+1];
               end
               win_in[ACT_WINDOW-1] = in_cycle_ff;
               if (cnt_ff != CNT_FULL) begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
            end
            dbt_pkg::FUNC_READ: begin
               state_in      = dbt_pkg::ST_READING;
               busy_until_in = cyc_ext + SUM_W'(t_cas_ff);
               busy_vld_in   = 1'b1;
               last_rd_in    = in_cycle_ff;
               rd_vld_in     = 1'b1;
            end
            dbt_pkg::FUNC_WRITE: begin
               state_in      = dbt_pkg::ST_WRITING;
               busy_until_in = cyc_ext + SUM_W'(t_cas_ff);
               busy_vld_in   = 1'b1;
               last_wr_in    = in_cycle_ff;
               wr_vld_in     = 1'b1;
            end
            dbt_pkg::FUNC_PRECHARGE: begin
               state_in      = dbt_pkg::ST_PRECHARGING;
               busy_until_in = cyc_ext + SUM_W'(t_rp_ff);
               busy_vld_in   = 1'b1;
               last_pre_in   = in_cycle_ff;
               pre_vld_in    = 1'b1;
            end
            dbt_pkg::FUNC_REFRESH: begin
               state_in      = dbt_pkg::ST_REFRESHING;
               busy_until_in = cyc_ext + SUM_W'(t_rfc_ff);
               busy_vld_in   = 1'b1;
            end
            dbt_pkg::FUNC_TICK: begin
               // retire the busy period once its end cycle is reached
               if (tick_due) begin
                  busy_vld_in = 1'b0;
                  priority if (state_ff == dbt_pkg::ST_ACTIVATING ||
                               state_ff == dbt_pkg::ST_READING ||
                               state_ff == dbt_pkg::ST_WRITING) begin
                     state_in = dbt_pkg::ST_ACTIVE;
                  end else if (state_ff == dbt_pkg::ST_PRECHARGING ||
                               state_ff == dbt_pkg::ST_REFRESHING) begin
                     state_in = dbt_pkg::ST_IDLE;
                  end else begin
                     state_in = state_ff;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // Handshake next values
   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_valid && req_ready) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
      rsp_vld_in = rsp_vld_ff;
      if (advance) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   // Control state and timing registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff   <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         state_ff    <= dbt_pkg::ST_IDLE;
         row_ff      <= '0;
         busy_vld_ff <= 1'b0;
         act_vld_ff  <= 1'b0;
         pre_vld_ff  <= 1'b0;
         rd_vld_ff   <= 1'b0;
         wr_vld_ff   <= 1'b0;
         cnt_ff      <= '0;
         t_rcd_ff    <= dbt_pkg::RST_T_RCD;
         t_rp_ff     <= dbt_pkg::RST_T_RP;
         t_ras_ff    <= dbt_pkg::RST_T_RAS;
         t_rc_ff     <= dbt_pkg::RST_T_RC;
         t_cas_ff    <= dbt_pkg::RST_T_CAS;
         t_ccd_ff    <= dbt_pkg::RST_T_CCD;
         t_wr_ff     <= dbt_pkg::RST_T_WR;
         t_rfc_ff    <= dbt_pkg::RST_T_RFC;
      end else begin
         in_vld_ff   <= in_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
         state_ff    <= state_in;
         row_ff      <= row_in;
         busy_vld_ff <= busy_vld_in;
         act_vld_ff  <= act_vld_in;
         pre_vld_ff  <= pre_vld_in;
         rd_vld_ff   <= rd_vld_in;
         wr_vld_ff   <= wr_vld_in;
         cnt_ff      <= cnt_in;
         if (csr_valid && csr_ready) begin
            unique case (dbt_pkg::csr_index_type'(csr_index))
               dbt_pkg::CSR_T_RCD: t_rcd_ff <= csr_data[dbt_pkg::TMG_W-1:0];
               dbt_pkg::CSR_T_RP:  t_rp_ff  <= csr_data[dbt_pkg::TMG_W-1:0];
               dbt_pkg::CSR_T_RAS: t_ras_ff <= csr_data[dbt_pkg::TMG_W-1:0];
               dbt_pkg::CSR_T_RC:  t_rc_ff  <= csr_data[dbt_pkg::TMG_W-1:0];
               dbt_pkg::CSR_T_CAS: t_cas_ff <= csr_data[dbt_pkg::TMG_W-1:0];
               dbt_pkg::CSR_T_CCD: t_ccd_ff <= csr_data[dbt_pkg::TMG_W-1:0];
               dbt_pkg::CSR_T_WR:  t_wr_ff  <= csr_data[dbt_pkg::TMG_W-1:0];
               dbt_pkg::CSR_T_RFC: t_rfc_ff <= csr_data[dbt_pkg::RFC_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Payload registers: stage the transaction, capture stamps and the result
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_func_ff  <= req_func;
         in_cycle_ff <= req_cycle;
         in_row_ff   <= req_row;
      end
      busy_until_ff <= busy_until_in;
      last_act_ff   <= last_act_in;
      last_pre_ff   <= last_pre_in;
      last_rd_ff    <= last_rd_in;
      last_wr_ff    <= last_wr_in;
      win_ff        <= win_in;
      if (advance) begin
         rsp_acc_ff   <= ok;
         rsp_state_ff <= state_in;
         rsp_row_ff   <= row_in;
      end
   end

   assign rsp_valid      = rsp_vld_ff;
   assign rsp_accepted   = rsp_acc_ff;
   assign rsp_bank_state = rsp_state_ff;
   assign rsp_open_row   = rsp_row_ff;

   // A bank without a pending busy end is settled: idle or active
   a_busy_end: assert property (@(posedge clock) disable iff (reset)
      !busy_vld_ff |-> (state_ff == dbt_pkg::ST_IDLE || state_ff == dbt_pkg::ST_ACTIVE))
      else $error("bank in a busy state without a recorded end cycle");

   // The activate count saturates at the window depth
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_FULL)
      else $error("activate count beyond window depth");

   // A processed transaction always shows up in the result register
   a_adv_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_vld_ff)
      else $error("processed transaction lost its result");

   // A refused input always has a staged transaction blocked behind the result
   a_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_vld_ff && rsp_vld_ff && !rsp_ready))
      else $error("input refused without a blocked stage");

endmodule

// ===== tb/sv/bank_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the DRAM bank timing state machine testbench.
// Watches the command, result and timing register channels, predicts every
// result from its own bank model and compares it. Depends on dbt_pkg.
module bank_result_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic [31:0] req_cycle,
   input  logic [16:0] req_row,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_accepted,
   input  logic [2:0]  rsp_bank_state,
   input  logic [16:0] rsp_open_row,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [11:0] csr_data,
   output int          fail_count,
   output int          pending_count
);

   localparam int RW        = dbt_pkg::DEF_ROW_BITS;
   localparam int WIN       = dbt_pkg::DEF_ACT_WINDOW;
   localparam int EXP_DEPTH = 8;

   typedef struct packed {
      logic                    accepted;
      dbt_pkg::bank_state_type bank_state;
      logic [RW-1:0]           open_row;
   } bank_result_type;

   // Cycle of the last command of one kind, with a valid bit
   typedef struct packed {
      logic [32:0] at;
      logic        vld;
   } cmd_stamp_type;

   // Timing settings as the block should hold them
   logic [dbt_pkg::TMG_W-1:0] t_rcd, t_rp, t_ras, t_rc, t_cas, t_ccd, t_wr;
   logic [dbt_pkg::RFC_W-1:0] t_rfc;

   // Bank model
   dbt_pkg::bank_state_type bank_st;
   logic [RW-1:0]  open_row_q;
   logic [32:0]    busy_end;
   logic           busy_vld;
   cmd_stamp_type  act_stamp, pre_stamp, rd_stamp, wr_stamp;
   logic [31:0]    faw_win [WIN];
   int             faw_cnt;

   // Expected results in order, as a ring with free-running counters
   bank_result_type exp_fifo [EXP_DEPTH];
   int              exp_wr;
   int              exp_rd;

   function automatic logic gap_met(cmd_stamp_type s, logic [32:0] cyc, logic [11:0] gap);
      return !s.vld || (cyc >= s.at + {21'd0, gap});
   endfunction

   function automatic cmd_stamp_type stamp_at(logic [32:0] cyc);
      cmd_stamp_type s;
      s.at  = cyc;
      s.vld = 1'b1;
      return s;
   endfunction

   task start_busy(input dbt_pkg::bank_state_type st, input logic [32:0] cyc,
                   input logic [11:0] dur);
      bank_st  = st;
      busy_end = cyc + {21'd0, dur};
      busy_vld = 1'b1;
   endtask

   task reset_bank_model;
      t_rcd      = dbt_pkg::RST_T_RCD;
      t_rp       = dbt_pkg::RST_T_RP;
      t_ras      = dbt_pkg::RST_T_RAS;
      t_rc       = dbt_pkg::RST_T_RC;
      t_cas      = dbt_pkg::RST_T_CAS;
      t_ccd      = dbt_pkg::RST_T_CCD;
      t_wr       = dbt_pkg::RST_T_WR;
      t_rfc      = dbt_pkg::RST_T_RFC;
      bank_st    = dbt_pkg::ST_IDLE;
      open_row_q = '0;
      busy_end   = '0;
      busy_vld   = 1'b0;
      act_stamp  = '0;
      pre_stamp  = '0;
      rd_stamp   = '0;
      wr_stamp   = '0;
      faw_cnt    = 0;
   endtask

   // Apply one command to the bank model and return the result it gives
   task predict_command(input logic [2:0] func, input logic [31:0] cycle_in,
                        input logic [RW-1:0] row, output bank_result_type res);
      logic [32:0] cyc;
      logic        ok;
      logic        col_ok;
      int          i;
      cyc    = {1'b0, cycle_in};
      ok     = 1'b0;
      col_ok = (bank_st == dbt_pkg::ST_ACTIVE) || (bank_st == dbt_pkg::ST_READING) ||
               (bank_st == dbt_pkg::ST_WRITING);
      unique case (func)
         dbt_pkg::FUNC_ACTIVATE: begin
            if (bank_st == dbt_pkg::ST_IDLE &&
                !(faw_cnt >= WIN &&
                  cyc < {1'b0, faw_win[0]} + 33'(dbt_pkg::DEF_T_FAW)) &&
                gap_met(pre_stamp, cyc, {2'b00, t_rp}) &&
                gap_met(act_stamp, cyc, {2'b00, t_rc})) begin
               ok         = 1'b1;
               open_row_q = row;
               start_busy(dbt_pkg::ST_ACTIVATING, cyc, {2'b00, t_rcd});
               act_stamp  = stamp_at(cyc);
               // slide the four-activate window
               if (faw_cnt < WIN) begin
                  faw_win[faw_cnt] = cycle_in;
                  faw_cnt++;
               end else begin
                  for (i = 0; i + 1 < WIN; i++) faw_win[i] = faw_win[i+1];
                  faw_win[WIN-1] = cycle_in;
               end
            end
         end
         dbt_pkg::FUNC_READ: begin
            if (col_ok && gap_met(rd_stamp, cyc, {2'b00, t_ccd}) &&
                gap_met(wr_stamp, cyc, 12'(dbt_pkg::DEF_T_WTR))) begin
               ok = 1'b1;
               start_busy(dbt_pkg::ST_READING, cyc, {2'b00, t_cas});
               rd_stamp = stamp_at(cyc);
            end
         end
         dbt_pkg::FUNC_WRITE: begin
            if (col_ok && gap_met(wr_stamp, cyc, {2'b00, t_ccd}) &&
                gap_met(rd_stamp, cyc, {2'b00, t_cas})) begin
               ok = 1'b1;
               start_busy(dbt_pkg::ST_WRITING, cyc, {2'b00, t_cas});
               wr_stamp = stamp_at(cyc);
            end
         end
         dbt_pkg::FUNC_PRECHARGE: begin
            if (bank_st == dbt_pkg::ST_ACTIVE && gap_met(act_stamp, cyc, {2'b00, t_ras}) &&
                gap_met(wr_stamp, cyc, {2'b00, t_wr})) begin
               ok = 1'b1;
               start_busy(dbt_pkg::ST_PRECHARGING, cyc, {2'b00, t_rp});
               pre_stamp = stamp_at(cyc);
            end
         end
         dbt_pkg::FUNC_REFRESH: begin
            if (bank_st == dbt_pkg::ST_IDLE) begin
               ok = 1'b1;
               start_busy(dbt_pkg::ST_REFRESHING, cyc, t_rfc);
            end
         end
         dbt_pkg::FUNC_TICK: begin
            ok = 1'b1;
            // retire the busy state once its end cycle is reached
            if (busy_vld && cyc >= busy_end) begin
               unique case (bank_st)
                  dbt_pkg::ST_ACTIVATING, dbt_pkg::ST_READING, dbt_pkg::ST_WRITING:
                     bank_st = dbt_pkg::ST_ACTIVE;
                  dbt_pkg::ST_PRECHARGING, dbt_pkg::ST_REFRESHING:
                     bank_st = dbt_pkg::ST_IDLE;
                  default: ;
               endcase
               busy_vld = 1'b0;
            end
         end
         default: ok = 1'b0;
      endcase
      res.accepted   = ok;
      res.bank_state = bank_st;
      res.open_row   = open_row_q;
   endtask

   always @(posedge clock) begin : watch
      bank_result_type want;
      bank_result_type pred;
      if (reset) begin
         reset_bank_model();
         exp_wr = 0;
         exp_rd = 0;
      end else begin
         // compare a result transaction with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (exp_wr == exp_rd) begin
               $display("%0t: unexpected result: accepted %0d state %0d row %0h",
                        $time, rsp_accepted, rsp_bank_state, rsp_open_row);
               fail_count++;
            end else begin
               want = exp_fifo[exp_rd % EXP_DEPTH];
               exp_rd++;
               if (rsp_accepted !== want.accepted) begin
                  $display("%0t: accepted mismatch: expected %0d, actual %0d",
                           $time, want.accepted, rsp_accepted);
                  fail_count++;
               end
               if (rsp_bank_state !== want.bank_state) begin
                  $display("%0t: bank_state mismatch: expected %0d, actual %0d",
                           $time, want.bank_state, rsp_bank_state);
                  fail_count++;
               end
               if (rsp_open_row !== want.open_row) begin
                  $display("%0t: open_row mismatch: expected %0h, actual %0h",
                           $time, want.open_row, rsp_open_row);
                  fail_count++;
               end
            end
         end
         // track timing register writes
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               dbt_pkg::CSR_T_RCD: t_rcd = csr_data[dbt_pkg::TMG_W-1:0];
               dbt_pkg::CSR_T_RP:  t_rp  = csr_data[dbt_pkg::TMG_W-1:0];
               dbt_pkg::CSR_T_RAS: t_ras = csr_data[dbt_pkg::TMG_W-1:0];
               dbt_pkg::CSR_T_RC:  t_rc  = csr_data[dbt_pkg::TMG_W-1:0];
               dbt_pkg::CSR_T_CAS: t_cas = csr_data[dbt_pkg::TMG_W-1:0];
               dbt_pkg::CSR_T_CCD: t_ccd = csr_data[dbt_pkg::TMG_W-1:0];
               dbt_pkg::CSR_T_WR:  t_wr  = csr_data[dbt_pkg::TMG_W-1:0];
               dbt_pkg::CSR_T_RFC: t_rfc = csr_data[dbt_pkg::RFC_W-1:0];
               default: ;
            endcase
         end
         // predict each accepted command transaction
         if (req_valid && req_ready) begin
            predict_command(req_func, req_cycle, req_row, pred);
            if (exp_wr - exp_rd >= EXP_DEPTH) begin
               $display("%0t: more transactions in flight than the block can hold: %0d",
                        $time, exp_wr - exp_rd);
               fail_count++;
            end else begin
               exp_fifo[exp_wr % EXP_DEPTH] = pred;
               exp_wr++;
            end
         end
      end
      pending_count = exp_wr - exp_rd;
   end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the DRAM bank timing state machine: clock, reset, command
// and timing register stimulus, back-pressure and the verdict.
// Depends on dbt_pkg, dram_bank_timing_fsm and bank_result_checker.
module tb_top;

   localparam int RW = dbt_pkg::DEF_ROW_BITS;
   localparam int CW = dbt_pkg::DEF_CYCLE_BITS;

   // Command codes the block must ignore
   localparam logic [2:0] FUNC_UNUSED_A = 3'd6;
   localparam logic [2:0] FUNC_UNUSED_B = 3'd7;

   logic          clock     = 1'b0;
   logic          reset     = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   logic [2:0]    req_func  = '0;
   logic [CW-1:0] req_cycle = '0;
   logic [RW-1:0] req_row   = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic          rsp_accepted;
   logic [2:0]    rsp_bank_state;
   logic [RW-1:0] rsp_open_row;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   logic [2:0]    csr_index = '0;
   logic [11:0]   csr_data  = '0;

   int fail_count;
   int pending_count;

   int tx_idle_pct = 28;
   int rx_idle_pct = 75;
   int hold_req    = 0;
   int hold_seen   = 0;
   int hold_left   = 0;
   int sent        = 0;
   longint unsigned now_cyc = 0;
   int tmg [8];

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   dram_bank_timing_fsm i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_func(req_func),
      .req_cycle(req_cycle), .req_row(req_row),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_accepted(rsp_accepted),
      .rsp_bank_state(rsp_bank_state), .rsp_open_row(rsp_open_row),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   bank_result_checker i_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_func(req_func),
      .req_cycle(req_cycle), .req_row(req_row),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_accepted(rsp_accepted),
      .rsp_bank_state(rsp_bank_state), .rsp_open_row(rsp_open_row),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   // Result side: random stalls, plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_seen != hold_req) begin
         hold_seen = hold_req;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   // Offer one command transaction and hold it until accepted
   task automatic push_cmd(input logic [2:0] f, input logic [CW-1:0] cyc,
                           input logic [RW-1:0] row);
      @(negedge clock);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= f;
      req_cycle <= cyc;
      req_row   <= row;
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   // Advance the command clock by gap, saturating at the top of the range
   task automatic issue_cmd(input logic [2:0] f, input int gap, input logic [RW-1:0] row);
      logic [CW-1:0] cyc;
      now_cyc += gap;
      cyc = (now_cyc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : now_cyc[CW-1:0];
      push_cmd(f, cyc, row);
   endtask

   // Drop valid and wait until every predicted result has arrived
   task automatic drain_results;
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic set_timing(input dbt_pkg::csr_index_type idx, input logic [11:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      tmg[idx] = (idx == dbt_pkg::CSR_T_RFC) ? int'(val) : int'(val[dbt_pkg::TMG_W-1:0]);
   endtask

   task automatic load_defaults;
      set_timing(dbt_pkg::CSR_T_RCD, {2'b00, dbt_pkg::RST_T_RCD});
      set_timing(dbt_pkg::CSR_T_RP,  {2'b00, dbt_pkg::RST_T_RP});
      set_timing(dbt_pkg::CSR_T_RAS, {2'b00, dbt_pkg::RST_T_RAS});
      set_timing(dbt_pkg::CSR_T_RC,  {2'b00, dbt_pkg::RST_T_RC});
      set_timing(dbt_pkg::CSR_T_CAS, {2'b00, dbt_pkg::RST_T_CAS});
      set_timing(dbt_pkg::CSR_T_CCD, {2'b00, dbt_pkg::RST_T_CCD});
      set_timing(dbt_pkg::CSR_T_WR,  {2'b00, dbt_pkg::RST_T_WR});
      set_timing(dbt_pkg::CSR_T_RFC, dbt_pkg::RST_T_RFC);
   endtask

   // Gap close to a timing value, straddling its boundary
   function automatic int near_gap(int g);
      int d;
      d = g + int'($urandom_range(0, 6)) - 3;
      return (d < 0) ? 0 : d;
   endfunction

   function automatic logic [RW-1:0] any_row;
      logic [RW-1:0] r;
      r = RW'($urandom);
      return r;
   endfunction

   // One bank lifetime: optional refresh, activate, column commands, precharge
   task automatic bank_flow;
      int         gap;
      logic [2:0] f;
      if ($urandom_range(0, 4) == 0) begin
         issue_cmd(dbt_pkg::FUNC_REFRESH, $urandom_range(0, 3), any_row());
         issue_cmd(dbt_pkg::FUNC_TICK, near_gap(tmg[dbt_pkg::CSR_T_RFC]), any_row());
         issue_cmd(dbt_pkg::FUNC_TICK, $urandom_range(0, 3), any_row());
      end
      issue_cmd(dbt_pkg::FUNC_ACTIVATE, near_gap(tmg[dbt_pkg::CSR_T_RP]), any_row());
      issue_cmd(dbt_pkg::FUNC_TICK, near_gap(tmg[dbt_pkg::CSR_T_RCD]), any_row());
      repeat ($urandom_range(1, 5)) begin
         f = $urandom_range(0, 1) ? dbt_pkg::FUNC_READ : dbt_pkg::FUNC_WRITE;
         case ($urandom_range(0, 2))
            0:       gap = tmg[dbt_pkg::CSR_T_CCD];
            1:       gap = dbt_pkg::DEF_T_WTR;
            default: gap = tmg[dbt_pkg::CSR_T_CAS];
         endcase
         issue_cmd(f, near_gap(gap), any_row());
         if ($urandom_range(0, 1)) begin
            issue_cmd(dbt_pkg::FUNC_TICK, near_gap(tmg[dbt_pkg::CSR_T_CAS]), any_row());
         end
      end
      issue_cmd(dbt_pkg::FUNC_TICK, near_gap(tmg[dbt_pkg::CSR_T_CAS]), any_row());
      issue_cmd(dbt_pkg::FUNC_PRECHARGE, near_gap(tmg[dbt_pkg::CSR_T_WR]), any_row());
      issue_cmd(dbt_pkg::FUNC_PRECHARGE, near_gap(tmg[dbt_pkg::CSR_T_RAS] / 2), any_row());
      issue_cmd(dbt_pkg::FUNC_TICK, near_gap(tmg[dbt_pkg::CSR_T_RP]), any_row());
   endtask

   // Any code, short gaps, sometimes a cycle that steps backward
   task automatic noise_cmd;
      logic [2:0]      f;
      longint unsigned c;
      int              back;
      f = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 3) == 0) begin
         back = $urandom_range(0, 40);
         c = (now_cyc > back) ? now_cyc - back : 0;
         push_cmd(f, (c > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : c[CW-1:0], any_row());
      end else begin
         issue_cmd(f, $urandom_range(0, 12), any_row());
      end
   endtask

   task automatic random_items(input int count);
      int stop;
      stop = sent + count;
      while (sent < stop) begin
         if ($urandom_range(0, 99) < 80) bank_flow();
         else noise_cmd();
      end
   endtask

   initial begin
      int          i;
      logic [11:0] v;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      load_defaults();

      // Directed: illegal commands when idle, ignored codes, refresh,
      // tick boundaries, column gaps, read/write turnaround, tRAS limit
      push_cmd(dbt_pkg::FUNC_READ, 0, '0);
      push_cmd(dbt_pkg::FUNC_PRECHARGE, 0, '0);
      push_cmd(dbt_pkg::FUNC_TICK, 0, '0);
      push_cmd(FUNC_UNUSED_A, 0, '1);
      push_cmd(FUNC_UNUSED_B, 0, '1);
      push_cmd(dbt_pkg::FUNC_REFRESH, 0, '0);
      push_cmd(dbt_pkg::FUNC_ACTIVATE, 10, '1);
      push_cmd(dbt_pkg::FUNC_TICK, 559, '0);
      push_cmd(dbt_pkg::FUNC_TICK, 560, '0);
      push_cmd(dbt_pkg::FUNC_ACTIVATE, 560, '1);
      push_cmd(dbt_pkg::FUNC_TICK, 581, '0);
      push_cmd(dbt_pkg::FUNC_TICK, 582, '0);
      push_cmd(dbt_pkg::FUNC_READ, 582, '0);
      push_cmd(dbt_pkg::FUNC_READ, 589, '0);
      push_cmd(dbt_pkg::FUNC_TICK, 604, '0);
      push_cmd(dbt_pkg::FUNC_WRITE, 604, '0);
      push_cmd(dbt_pkg::FUNC_READ, 610, '0);
      push_cmd(dbt_pkg::FUNC_READ, 616, '0);
      push_cmd(dbt_pkg::FUNC_WRITE, 620, '0);
      push_cmd(dbt_pkg::FUNC_TICK, 638, '0);
      push_cmd(dbt_pkg::FUNC_PRECHARGE, 638, '0);
      push_cmd(dbt_pkg::FUNC_TICK, 660, '0);
      push_cmd(dbt_pkg::FUNC_ACTIVATE, 660, '0);
      push_cmd(dbt_pkg::FUNC_TICK, 682, '0);
      push_cmd(dbt_pkg::FUNC_PRECHARGE, 700, '0);
      push_cmd(dbt_pkg::FUNC_PRECHARGE, 712, '0);
      now_cyc = 712;

      // Default timing, slow receiver
      random_items(400);
      drain_results();

      // Small timings so the activate window binds; slow sender
      tx_idle_pct = 75;
      rx_idle_pct = 28;
      for (i = 0; i < 8; i++) begin
         if (dbt_pkg::csr_index_type'(i) == dbt_pkg::CSR_T_RFC) begin
            v = 12'($urandom_range(0, 63));
         end else begin
            v = {2'($urandom_range(0, 3)), 6'd0, 4'($urandom_range(0, 15))};
         end
         set_timing(dbt_pkg::csr_index_type'(i), v);
      end
      random_items(400);
      drain_results();

      // All timings zero, no idling from here on
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      for (i = 0; i < 8; i++) set_timing(dbt_pkg::csr_index_type'(i), 12'd0);
      random_items(200);
      drain_results();

      // All timings at their maximum
      for (i = 0; i < 8; i++) set_timing(dbt_pkg::csr_index_type'(i), 12'hFFF);
      random_items(150);
      drain_results();

      // Random timings; long receiver hold-off, then a full pause
      for (i = 0; i < 8; i++) begin
         set_timing(dbt_pkg::csr_index_type'(i), 12'($urandom_range(0, 4095)));
      end
      hold_req++;
      random_items(100);
      drain_results();
      random_items(100);
      drain_results();

      // Defaults again near the top of the cycle range
      load_defaults();
      now_cyc = 64'hFFFF_C000;
      random_items(250);
      issue_cmd(dbt_pkg::FUNC_TICK, 32'h7FFF_FFFF, '1);
      drain_results();
      repeat (8) @(negedge clock);

      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Hang guard
   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
